// File: hw/rtl/tqga_pkg.sv
// tqga_pkg: shared types and constants for the
// two-qubit gate block. No dependencies.
`default_nettype none
package tqga_pkg;
    localparam int MAX_QUBITS_DEF = 10;
    localparam int COMPONENT_BITS_DEF = 32;
    localparam int CFG_IDX_BITS = 2;
    localparam int CFG_DATA_BITS = 4;
    localparam int IDX_BITS = 10;
    localparam int NUMQ_BITS = 4;
    localparam int VAL_BITS = 32;

    typedef enum logic [1:0] {
        KIND_WRITE_AMP  = 2'd0,
        KIND_WRITE_GATE = 2'd1,
        KIND_COMPUTE    = 2'd2,
        KIND_UNUSED     = 2'd3
    } kind_t;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_NUM_QUBITS   = 2'd0,
        REG_QUBIT_FIRST  = 2'd1,
        REG_QUBIT_SECOND = 2'd2,
        REG_NONE         = 2'd3
    } cfg_reg_t;

    // result beat toward the output register
    typedef struct packed {
        logic [IDX_BITS-1:0] idx;
        logic [VAL_BITS-1:0] re;
        logic [VAL_BITS-1:0] im;
        logic                last;
        logic                err;
    } result_t;
endpackage
`default_nettype wire

// File: hw/rtl/tqga_ram.sv
// tqga_ram: generic single-port-write, single-read synchronous RAM with
// registered read data. No dependencies.
`default_nettype none
module tqga_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// File: hw/rtl/tqga_mac.sv
// tqga_mac: complex multiply-accumulate with per-product rounding and
// final saturation. Depends on tqga_pkg.
`default_nettype none
module tqga_mac #(
    parameter int CB = tqga_pkg::COMPONENT_BITS_DEF
) (
    input  wire logic          aclk,
    input  wire logic          clr,
    input  wire logic          en,
    input  wire logic [CB-1:0] g_re,
    input  wire logic [CB-1:0] g_im,
    input  wire logic [CB-1:0] a_re,
    input  wire logic [CB-1:0] a_im,
    output logic      [CB-1:0] sat_re,
    output logic      [CB-1:0] sat_im
);
    import tqga_pkg::*;
    localparam int FB = CB - 2;
    localparam int PW = 2 * CB;
    localparam int RW = PW - FB;
    localparam int AW = RW + 3;

    logic signed [PW-1:0] p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg;
    logic                 p_vld_reg;
    logic signed [AW-1:0] acc_re_reg, acc_im_reg;
    logic signed [AW-1:0] add_re, add_im;
    logic signed [PW-1:0] half;

    function automatic logic signed [RW-1:0] rnd(input logic signed [PW-1:0] p,
                                                 input logic signed [PW-1:0] h);
        logic signed [PW-1:0] q;
        begin
            q = p + h;
            rnd = RW'(q >>> FB);
        end
    endfunction

    function automatic logic [CB-1:0] sat(input logic signed [AW-1:0] s);
        logic signed [AW-1:0] hi, lo;
        begin
            hi = AW'((PW'(1) <<< (CB - 1)) - PW'(1));
            lo = -hi - AW'(1);
            if (s > hi) sat = hi[CB-1:0];
            else if (s < lo) sat = lo[CB-1:0];
            else sat = s[CB-1:0];
        end
    endfunction

    assign half = PW'(1) <<< (FB - 1);
    assign add_re = AW'(rnd(p_rr_reg, half)) - AW'(rnd(p_ii_reg, half));
    assign add_im = AW'(rnd(p_ri_reg, half)) + AW'(rnd(p_ir_reg, half));

    always_ff @(posedge aclk) begin
        p_rr_reg  <= PW'($signed(g_re)) * PW'($signed(a_re));
        p_ii_reg  <= PW'($signed(g_im)) * PW'($signed(a_im));
        p_ri_reg  <= PW'($signed(g_re)) * PW'($signed(a_im));
        p_ir_reg  <= PW'($signed(g_im)) * PW'($signed(a_re));
        p_vld_reg <= en;
        if (clr) begin
            acc_re_reg <= '0;
            acc_im_reg <= '0;
        end else if (p_vld_reg) begin
            acc_re_reg <= acc_re_reg + add_re;
            acc_im_reg <= acc_im_reg + add_im;
        end
    end

    assign sat_re = sat(acc_re_reg);
    assign sat_im = sat(acc_im_reg);
endmodule
`default_nettype wire

// File: hw/rtl/two_qubit_gate_apply.sv
// two_qubit_gate_apply: top level, sequencer plus amplitude/gate memories
// and complex MAC. Depends on tqga_pkg, tqga_ram, tqga_mac.
//
// Usage: input beats on s_* load amplitudes (kind 0), gate entries (kind 1)
// or request a group computation (kind 2). Writes yield nothing. A compute
// beat walks 16 memory reads (4 columns per output row). Each row makes
// 4 reads in S_READ, drains the read and product pipeline in S_DRAIN and
// emits one output beat in S_OUT; the last beat is flagged by last, and the
// next input is taken only once the sequencer is back in idle via S_WAIT.
// A bad configuration or out-of-range group yields a single beat with error
// and last set on the next cycle.
// The amplitude memory is one 1024x64 RAM with one read port; that port
// sets the rate of one column per cycle.
// Config beats on cfg_* are accepted at any time; write only when idle.
// Reset clears configuration to num_qubits=2, first=0, second=1, and the
// sequencer; memory contents are undefined until written.
// When the receiver stalls, the result waits in the output register and
// no further input is taken until the item's results are all delivered.
`default_nettype none
module two_qubit_gate_apply #(
    parameter int MAX_QUBITS     = tqga_pkg::MAX_QUBITS_DEF,
    parameter int COMPONENT_BITS = tqga_pkg::COMPONENT_BITS_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic [1:0]                       s_kind,
    input  wire logic [tqga_pkg::IDX_BITS-1:0]    s_index,
    input  wire logic signed [tqga_pkg::VAL_BITS-1:0] s_value_re,
    input  wire logic signed [tqga_pkg::VAL_BITS-1:0] s_value_im,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic [tqga_pkg::IDX_BITS-1:0]         m_out_index,
    output logic signed [tqga_pkg::VAL_BITS-1:0]  m_out_re,
    output logic signed [tqga_pkg::VAL_BITS-1:0]  m_out_im,
    output logic                                  m_last,
    output logic                                  m_error,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [tqga_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [tqga_pkg::CFG_DATA_BITS-1:0] cfg_data
);
    import tqga_pkg::*;

    localparam int CB = COMPONENT_BITS;
    localparam int AB = MAX_QUBITS;
    localparam int DEPTH = 1 << MAX_QUBITS;
    localparam int GW = 2 * CB;

    typedef enum logic [2:0] {
        S_IDLE, S_READ, S_DRAIN, S_OUT, S_WAIT
    } state_t;

    state_t state_reg;
    logic [NUMQ_BITS-1:0] nq_reg, qf_reg, qs_reg;
    logic [1:0] col_reg, row_reg;
    logic [2:0] drain_reg;
    logic [AB-1:0] base_reg;
    logic [AB-1:0] mj_reg, mi_reg;
    logic mac_en_reg, mac_clr_reg;
    logic mac_clr_next;
    result_t res_reg;
    logic m_valid_reg;

    logic s_acc;
    logic [CB-1:0] s_re_c, s_im_c;
    logic amp_we, gate_we;
    logic [AB-1:0] amp_raddr;
    logic [GW-1:0] amp_rdata, gate_rdata;
    logic [CB-1:0] mac_re, mac_im;
    logic bad;
    logic [NUMQ_BITS-1:0] pj, pi;
    logic [AB-1:0] grp, base_c, t1, low1, low2;

    assign s_ready   = (state_reg == S_IDLE) && !m_valid_reg;
    assign s_acc     = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign s_re_c    = s_value_re[CB-1:0];
    assign s_im_c    = s_value_im[CB-1:0];
    assign amp_we    = s_acc && (s_kind == KIND_WRITE_AMP);
    assign gate_we   = s_acc && (s_kind == KIND_WRITE_GATE) && (s_index < IDX_BITS'(16));

    // address for the current column: bits j (low) and i (high) of col
    always_comb begin
        amp_raddr = base_reg;
        if (col_reg[0]) amp_raddr = amp_raddr | mj_reg;
        if (col_reg[1]) amp_raddr = amp_raddr | mi_reg;
    end

    tqga_ram #(.WIDTH(GW), .DEPTH(DEPTH)) u_amp (
        .aclk (aclk), .we (amp_we), .waddr (AB'(s_index)),
        .wdata ({s_re_c, s_im_c}), .raddr (amp_raddr), .rdata (amp_rdata)
    );

    tqga_ram #(.WIDTH(GW), .DEPTH(16)) u_gate (
        .aclk (aclk), .we (gate_we), .waddr (s_index[3:0]),
        .wdata ({s_re_c, s_im_c}), .raddr ({row_reg, col_reg}), .rdata (gate_rdata)
    );

    tqga_mac #(.CB(CB)) u_mac (
        .aclk (aclk), .clr (mac_clr_reg), .en (mac_en_reg),
        .g_re (gate_rdata[GW-1:CB]), .g_im (gate_rdata[CB-1:0]),
        .a_re (amp_rdata[GW-1:CB]), .a_im (amp_rdata[CB-1:0]),
        .sat_re (mac_re), .sat_im (mac_im)
    );

    // group decode: check and zero-bit insertion
    always_comb begin
        pj   = nq_reg - NUMQ_BITS'(1) - qs_reg;
        pi   = nq_reg - NUMQ_BITS'(1) - qf_reg;
        grp  = AB'(s_index);
        bad  = (qf_reg >= qs_reg) || (qs_reg >= nq_reg) || (32'(nq_reg) > MAX_QUBITS)
            || (32'(s_index) >= (32'(1) << (nq_reg - NUMQ_BITS'(2))))
            || (nq_reg < NUMQ_BITS'(2));
        low1 = (AB'(1) << pj) - AB'(1);
        t1   = ((grp & ~low1) << 1) | (grp & low1);
        low2 = (AB'(1) << pi) - AB'(1);
        base_c = ((t1 & ~low2) << 1) | (t1 & low2);
    end

    // accumulator clear at the start of every row
    always_comb begin
        mac_clr_next = 1'b0;
        if (s_acc && s_kind == KIND_COMPUTE && !bad) mac_clr_next = 1'b1;
        if (state_reg == S_OUT && (!m_valid_reg || m_ready)) mac_clr_next = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            nq_reg      <= NUMQ_BITS'(2);
            qf_reg      <= '0;
            qs_reg      <= NUMQ_BITS'(1);
            m_valid_reg <= 1'b0;
            mac_en_reg  <= 1'b0;
            mac_clr_reg <= 1'b0;
            col_reg     <= '0;
            row_reg     <= '0;
            drain_reg   <= '0;
        end else begin
            if (cfg_valid) begin
                case (cfg_reg_t'(cfg_index))
                    REG_NUM_QUBITS:   nq_reg <= cfg_data;
                    REG_QUBIT_FIRST:  qf_reg <= cfg_data;
                    REG_QUBIT_SECOND: qs_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (m_valid_reg && m_ready && state_reg != S_OUT) m_valid_reg <= 1'b0;
            // ram data lands next cycle; MAC enable follows it
            mac_en_reg  <= (state_reg == S_READ);
            mac_clr_reg <= mac_clr_next;
            case (state_reg)
                S_IDLE: begin
                    if (s_acc && s_kind == KIND_COMPUTE) begin
                        if (bad) begin
                            res_reg     <= '{idx: '0, re: '0, im: '0, last: 1'b1, err: 1'b1};
                            m_valid_reg <= 1'b1;
                        end else begin
                            base_reg    <= base_c;
                            mj_reg      <= AB'(1) << pj;
                            mi_reg      <= AB'(1) << pi;
                            row_reg     <= '0;
                            col_reg     <= '0;
                            state_reg   <= S_READ;
                        end
                    end
                end
                S_READ: begin
                    col_reg    <= col_reg + 2'd1;
                    if (col_reg == 2'd3) begin
                        drain_reg <= 3'd2;
                        state_reg <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    drain_reg <= drain_reg - 3'd1;
                    if (drain_reg == 3'd0) state_reg <= S_OUT;
                end
                S_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        res_reg.idx  <= IDX_BITS'(base_reg
                                        | (row_reg[0] ? mj_reg : '0)
                                        | (row_reg[1] ? mi_reg : '0));
                        res_reg.re   <= VAL_BITS'($signed(mac_re));
                        res_reg.im   <= VAL_BITS'($signed(mac_im));
                        res_reg.last <= (row_reg == 2'd3);
                        res_reg.err  <= 1'b0;
                        m_valid_reg  <= 1'b1;
                        row_reg      <= row_reg + 2'd1;
                        state_reg    <= (row_reg == 2'd3) ? S_WAIT : S_READ;
                    end
                end
                S_WAIT: begin
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_out_index = res_reg.idx;
    assign m_out_re    = res_reg.re;
    assign m_out_im    = res_reg.im;
    assign m_last      = res_reg.last;
    assign m_error     = res_reg.err;
endmodule
`default_nettype wire

// File: hw/rtl/tqga_checker.sv
// tqga_checker: port-level assertions for two_qubit_gate_apply, bound to
// the top level. Depends on tqga_pkg.
`default_nettype none
module tqga_checker (
    input wire logic aclk,
    input wire logic aresetn,
    input wire logic s_valid,
    input wire logic s_ready,
    input wire logic m_valid,
    input wire logic m_ready,
    input wire logic m_last,
    input wire logic m_error,
    input wire logic [tqga_pkg::VAL_BITS-1:0] m_out_re
);
    import tqga_pkg::*;

    a_err_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_error) |-> m_last) else $error("error beat without last");
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_error) |-> (m_out_re == '0)) else $error("error beat nonzero");
    a_no_take: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(s_valid && s_ready)) else $error("input taken while result pending");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_last)))
        else $error("result dropped under stall");
    a_rst: assert property (@(posedge aclk)
        !aresetn |=> !m_valid) else $error("valid after reset");
endmodule

bind two_qubit_gate_apply tqga_checker u_chk (
    .aclk (aclk), .aresetn (aresetn), .s_valid (s_valid), .s_ready (s_ready),
    .m_valid (m_valid), .m_ready (m_ready), .m_last (m_last), .m_error (m_error),
    .m_out_re (m_out_re)
);
`default_nettype wire
